// ===== rtl/core/fixed_step_tick_frame_pacer_macros.svh =====
// Assertion macros shared by the pacer RTL.
// Depends on the asserting module having i_clk and i_rst_n ports.
`ifndef FIXED_STEP_TICK_FRAME_PACER_MACROS_SVH
`define FIXED_STEP_TICK_FRAME_PACER_MACROS_SVH

// Condition holds at every clock edge outside reset
`define FSTP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define FSTP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fstp_pkg.sv =====
// Shared types and constants for the fixed-step tick/frame pacer.
// No dependencies.
package fstp_pkg;

    // Width of a whole-millisecond value and of the config registers
    localparam int MS_W = 32;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_FRAME = 2'd1,
        KIND_IDLE  = 2'd2
    } t_kind;

    // Config register indexes
    typedef enum logic [1:0] {
        CFG_TICK_LEN  = 2'd0,
        CFG_FRAME_LEN = 2'd1,
        CFG_MAX_DELTA = 2'd2,
        CFG_SKIP_EN   = 2'd3
    } t_cfg_idx;

    // Input opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Register reset values (ms, 16 fraction bits)
    localparam logic [MS_W-1:0] TICK_LEN_RST  = 32'd1092267;
    localparam logic [MS_W-1:0] FRAME_LEN_RST = 32'd1092267;
    localparam logic [MS_W-1:0] MAX_DELTA_RST = 32'd16384000;
    localparam logic            SKIP_EN_RST   = 1'b1;

endpackage

// ===== rtl/core/fstp_rem.sv =====
// Bit-serial restoring remainder unit: dividend mod divisor, one bit a cycle.
// Depends on fstp_pkg and fixed_step_tick_frame_pacer_macros.svh.
`include "fixed_step_tick_frame_pacer_macros.svh"

module fstp_rem
    import fstp_pkg::*;
#(
    parameter int TW = 48
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [TW-1:0]   i_dividend,
    input  logic [MS_W-1:0] i_divisor,
    output logic            o_done,
    output logic [MS_W-1:0] o_rem
);

    localparam int CW = $clog2(TW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [TW-1:0]   r_shift;
    logic [MS_W-1:0] r_rem;
    logic [MS_W-1:0] r_div;

    // partial remainder with the next dividend bit shifted in
    logic [MS_W:0] trial;
    logic [MS_W:0] trial_sub;
    logic          trial_ge;

    assign trial     = {r_rem, r_shift[TW-1]};
    assign trial_sub = trial - {1'b0, r_div};
    assign trial_ge  = (trial >= {1'b0, r_div});

    // one quotient bit per cycle, only the remainder is kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_shift <= i_dividend;
                r_rem   <= '0;
                r_div   <= i_divisor;
                r_cnt   <= CW'(TW);
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_shift <= r_shift << 1;
                r_rem   <= trial_ge ? trial_sub[MS_W-1:0] : trial[MS_W-1:0];
                r_cnt   <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    `FSTP_ASSERT_IMPLIES(a_rem_below_div, r_busy, r_rem < r_div, "remainder reached divisor")
    `FSTP_ASSERT_IMPLIES(a_done_not_busy, r_done, !r_busy, "done raised while still busy")

endmodule

// ===== rtl/core/fixed_step_tick_frame_pacer.sv =====
// Fixed-step tick and frame pacer, top level.
// Depends on fstp_pkg, fstp_rem and fixed_step_tick_frame_pacer_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries op and now_ms. A start
//   transaction loads last-event, next-tick and next-frame times from now and
//   produces no result. A step transaction produces one or more results on the
//   output channel (o_out_valid / i_out_stall); the final one carries o_last.
//   Step sequence: gap clamp and overdue check, then, when overdue frames are
//   skipped, the bit-serial remainder unit (one bit a cycle), then the tick
//   loop, a closing check (which may render a frame) and the hand-off of the
//   final result. The remainder unit and the tick loop set the cost.
//   Results go through a one-entry hold stage and an output register; a stall
//   on the output side holds the sequencer wherever it must pass a result on,
//   until the result is taken.
//   Reset clears the last-event, next-tick and next-frame times to zero, loads
//   the config defaults and drops any pending result. Config writes are taken
//   whenever i_cfg_we is high.
`include "fixed_step_tick_frame_pacer_macros.svh"

module fixed_step_tick_frame_pacer
    import fstp_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MAX_TICKS = 63
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // config write port
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [MS_W-1:0]         i_cfg_data,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_op,
    input  logic [MS_W-1:0]         i_now_ms,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_kind,
    output logic [MS_W+FRAC_BITS-1:0] o_event_time,
    output logic                    o_frame_follows,
    output logic                    o_capped,
    output logic [MS_W-1:0]         o_wake_ms,
    output logic                    o_last
);

    localparam int TW    = MS_W + FRAC_BITS;
    localparam int TW1   = TW + 1;
    localparam int CNT_W = $clog2(MAX_TICKS + 1);

    typedef struct packed {
        t_kind           kind;
        logic [TW-1:0]   evt;
        logic            ff;
        logic            capped;
        logic [MS_W-1:0] wake;
        logic            last;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAP,
        S_CLAMP,
        S_SHIFT,
        S_DIST,
        S_CHECK,
        S_DIV,
        S_SKIP,
        S_EVAL,
        S_TICK,
        S_FRAME,
        S_FRAME_EVAL,
        S_FLUSH
    } t_state;

    // config registers
    logic [MS_W-1:0] r_tick_len;
    logic [MS_W-1:0] r_frame_len;
    logic [MS_W-1:0] r_max_delta;
    logic            r_skip_en;

    // pacing state
    logic [TW-1:0]   r_let;
    logic [TW-1:0]   r_ntt;
    logic [TW-1:0]   r_nft;
    logic [TW-1:0]   r_now;
    logic [TW-1:0]   r_acc;
    logic            r_do;

    // sequencer
    t_state          r_state;
    logic [CNT_W-1:0] r_cnt;
    logic            r_tk;
    logic            r_cap;
    t_res            r_pend;
    logic            r_pend_v;
    t_res            r_out;
    logic            r_out_v;

    // remainder unit
    logic            div_start;
    logic            div_done;
    logic [MS_W-1:0] div_rem;

    logic            in_acc;
    logic            slot_free;
    logic [TW-1:0]   now_ext;
    logic [TW1-1:0]  clamp_diff;
    logic            clamp_hit;
    logic            skip_hit;
    logic [TW-1:0]   nft_m_ntt;
    logic [TW-1:0]   ntt_m_nft;
    logic [TW-1:0]   now_m_ntt;
    logic [TW-1:0]   now_m_nft;
    logic            fbt;
    logic            tick_past;
    logic            eq;
    logic            tick_due;
    logic            frame_due;
    logic [MS_W-1:0] wake_ms;
    logic            cnt_full;
    logic [TW-1:0]   tick_sum;
    logic [TW-1:0]   frame_sum;

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_v || !i_out_stall;
    assign now_ext   = TW'(i_now_ms) << FRAC_BITS;

    // gap clamp: gap above max_delta (gap taken as signed)
    assign clamp_diff = {1'b0, r_acc} - TW1'(r_max_delta);
    assign clamp_hit  = !r_acc[TW-1] && !clamp_diff[TW] && (clamp_diff[TW-1:0] != '0);

    // skip when at least two frame lengths overdue
    assign skip_hit = r_skip_en && (r_frame_len != '0) && !r_acc[TW-1] &&
                      ({1'b0, r_acc} >= TW1'({r_frame_len, 1'b0}));

    // wrap-aware ordering of the deadlines against each other and now
    assign nft_m_ntt = r_nft - r_ntt;
    assign ntt_m_nft = r_ntt - r_nft;
    assign now_m_ntt = r_now - r_ntt;
    assign now_m_nft = r_now - r_nft;
    assign fbt       = nft_m_ntt[TW-1];
    assign eq        = (r_nft == r_ntt);
    // next tick strictly later than the frame deadline
    assign tick_past = !ntt_m_nft[TW-1] && !eq;
    assign tick_due  = !fbt && !now_m_ntt[TW-1];
    assign frame_due = fbt ? !now_m_nft[TW-1] : (!now_m_ntt[TW-1] && eq);
    assign wake_ms   = fbt ? r_nft[FRAC_BITS +: MS_W] : r_ntt[FRAC_BITS +: MS_W];
    assign cnt_full  = (r_cnt == CNT_W'(MAX_TICKS));

    assign tick_sum  = r_ntt + TW'(r_tick_len);
    assign frame_sum = r_nft + TW'(r_frame_len);

    assign div_start = (r_state == S_CHECK) && skip_hit;

    fstp_rem #(
        .TW (TW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_frame_len),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // sequencer, pacing state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick_len  <= TICK_LEN_RST;
            r_frame_len <= FRAME_LEN_RST;
            r_max_delta <= MAX_DELTA_RST;
            r_skip_en   <= SKIP_EN_RST;
            r_let       <= '0;
            r_ntt       <= '0;
            r_nft       <= '0;
            r_cnt       <= '0;
            r_tk        <= 1'b0;
            r_cap       <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            // config writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TICK_LEN:  r_tick_len  <= i_cfg_data;
                    CFG_FRAME_LEN: r_frame_len <= i_cfg_data;
                    CFG_MAX_DELTA: r_max_delta <= i_cfg_data;
                    CFG_SKIP_EN:   r_skip_en   <= i_cfg_data[0];
                    default:       r_skip_en   <= r_skip_en;
                endcase
            end

            // output taken
            if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_op == OP_START) begin
                            r_let <= now_ext;
                            r_ntt <= now_ext;
                            r_nft <= now_ext;
                        end else begin
                            r_now   <= now_ext;
                            r_cnt   <= '0;
                            r_tk    <= 1'b0;
                            r_cap   <= 1'b0;
                            r_state <= S_GAP;
                        end
                    end
                end
                S_GAP: begin
                    r_acc   <= r_now - r_let;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_acc   <= clamp_diff[TW-1:0];
                    r_do    <= clamp_hit;
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (r_do) begin
                        r_ntt <= r_ntt + r_acc;
                        r_nft <= r_nft + r_acc;
                    end
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    r_acc   <= r_now - r_nft;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= skip_hit ? S_DIV : S_EVAL;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    // advance by whole frames: lands at now minus the remainder
                    r_nft   <= r_now - TW'(div_rem);
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (!(r_tk && r_pend_v && !slot_free)) begin
                        if (r_tk) begin
                            // older tick is not the final one
                            if (r_pend_v) begin
                                r_out        <= r_pend;
                                r_out.last   <= 1'b0;
                                r_out.capped <= 1'b0;
                                r_out_v      <= 1'b1;
                            end
                            r_pend.kind   <= KIND_TICK;
                            r_pend.evt    <= r_let;
                            r_pend.ff     <= tick_past;
                            r_pend.capped <= 1'b0;
                            r_pend.wake   <= wake_ms;
                            r_pend.last   <= 1'b0;
                            r_pend_v      <= 1'b1;
                            r_tk          <= 1'b0;
                        end
                        if (tick_due && !cnt_full) begin
                            r_state <= S_TICK;
                        end else if (tick_due) begin
                            r_cap   <= 1'b1;
                            r_state <= S_FLUSH;
                        end else if (frame_due) begin
                            r_state <= S_FRAME;
                        end else begin
                            if (r_cnt == '0) begin
                                r_pend.kind   <= KIND_IDLE;
                                r_pend.evt    <= r_let;
                                r_pend.ff     <= 1'b0;
                                r_pend.capped <= 1'b0;
                                r_pend.wake   <= wake_ms;
                                r_pend.last   <= 1'b0;
                                r_pend_v      <= 1'b1;
                            end
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_TICK: begin
                    r_ntt   <= tick_sum;
                    r_let   <= tick_sum;
                    r_cnt   <= r_cnt + 1'b1;
                    r_tk    <= 1'b1;
                    r_state <= S_EVAL;
                end
                S_FRAME: begin
                    r_nft   <= frame_sum;
                    r_let   <= frame_sum;
                    r_state <= S_FRAME_EVAL;
                end
                S_FRAME_EVAL: begin
                    if (!(r_pend_v && !slot_free)) begin
                        if (r_pend_v) begin
                            r_out        <= r_pend;
                            r_out.last   <= 1'b0;
                            r_out.capped <= 1'b0;
                            r_out_v      <= 1'b1;
                        end
                        r_pend.kind   <= KIND_FRAME;
                        r_pend.evt    <= r_let;
                        r_pend.ff     <= 1'b0;
                        r_pend.capped <= 1'b0;
                        r_pend.wake   <= wake_ms;
                        r_pend.last   <= 1'b0;
                        r_pend_v      <= 1'b1;
                        r_state       <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (slot_free) begin
                        r_out        <= r_pend;
                        r_out.last   <= 1'b1;
                        r_out.capped <= r_cap;
                        r_out_v      <= 1'b1;
                        r_pend_v     <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_v;
    assign o_kind          = r_out.kind;
    assign o_event_time    = r_out.evt;
    assign o_frame_follows = r_out.ff;
    assign o_capped        = r_out.capped;
    assign o_wake_ms       = r_out.wake;
    assign o_last          = r_out.last;

    `FSTP_ASSERT_IMPLIES(a_idle_no_pend, r_state == S_IDLE, !r_pend_v, "held result left behind")
    `FSTP_ASSERT_ALWAYS(a_cnt_bound, r_cnt <= CNT_W'(MAX_TICKS), "tick count above limit")
    `FSTP_ASSERT_IMPLIES(a_cap_final_tick, r_out_v && r_out.capped,
        r_out.last && (r_out.kind == KIND_TICK), "capped flag on non-final or non-tick result")

endmodule
